// File: hw/rtl/bpf_pkg.sv
// Shared types, constants and helper functions for the branch power flow unit.
// Used by bpf_cordic and branch_power_flow_unit; depends on nothing else.
`default_nettype none

package bpf_pkg;

    // Default number of CORDIC rotation stages.
    localparam int CORDIC_ITERATIONS_DEF = 24;

    // Angle constants in Q.20 radian.
    localparam int ANGLE_W = 26;
    localparam logic signed [ANGLE_W-1:0] PI_Q20      = 26'sd3294199;
    localparam logic signed [ANGLE_W-1:0] TWO_PI_Q20  = 26'sd6588398;
    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q20 = 26'sd1647099;

    // CORDIC datapath width and start gain in Q.30.
    localparam int CORDIC_W = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // Saturation bounds of the 48-bit results, held in a 50-bit compare width.
    localparam int SAT_W = 50;
    localparam logic signed [SAT_W-1:0] OUT_MAX = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [SAT_W-1:0] OUT_MIN = -50'sh0_8000_0000_0000;

    // Payload that rides along the CORDIC stages.
    typedef struct packed {
        logic [19:0]        vkm;
        logic signed [37:0] pa;
        logic signed [38:0] qb;
        logic signed [31:0] g;
        logic signed [31:0] b;
    } bpf_side_t;

    // Truncated arctangent table, Q.30.
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] r;
        case (idx)
            5'd0:  r = 30'h3243F6A8;
            5'd1:  r = 30'h1DAC6705;
            5'd2:  r = 30'h0FADBAFC;
            5'd3:  r = 30'h07F56EA6;
            5'd4:  r = 30'h03FEAB76;
            5'd5:  r = 30'h01FFD55B;
            5'd6:  r = 30'h00FFFAAA;
            5'd7:  r = 30'h007FFF55;
            5'd8:  r = 30'h003FFFEA;
            5'd9:  r = 30'h001FFFFD;
            5'd10: r = 30'h000FFFFF;
            5'd11: r = 30'h0007FFFF;
            5'd12: r = 30'h0003FFFF;
            5'd13: r = 30'h0001FFFF;
            5'd14: r = 30'h0000FFFF;
            5'd15: r = 30'h00007FFF;
            5'd16: r = 30'h00003FFF;
            5'd17: r = 30'h00001FFF;
            5'd18: r = 30'h00000FFF;
            5'd19: r = 30'h000007FF;
            5'd20: r = 30'h000003FF;
            5'd21: r = 30'h000001FF;
            5'd22: r = 30'h000000FF;
            5'd23: r = 30'h0000007F;
            5'd24: r = 30'h0000003F;
            5'd25: r = 30'h0000001F;
            5'd26: r = 30'h0000000F;
            5'd27: r = 30'h00000008;
            5'd28: r = 30'h00000004;
            5'd29: r = 30'h00000002;
            5'd30: r = 30'h00000001;
            default: r = 30'h00000000;
        endcase
        return r;
    endfunction

    // One wrap step of the angle toward [-PI, PI].
    function automatic logic signed [ANGLE_W-1:0] wrap_step(
        input logic signed [ANGLE_W-1:0] a);
        logic signed [ANGLE_W-1:0] r;
        if (a > PI_Q20)
            r = a - TWO_PI_Q20;
        else if (a < -PI_Q20)
            r = a + TWO_PI_Q20;
        else
            r = a;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bpf_cordic.sv
// Rotation-mode CORDIC pipeline, one register stage per iteration.
// Depends on bpf_pkg for the gain, the arctangent table and the sideband type.
`default_nettype none

module bpf_cordic #(
    parameter int ITERATIONS = bpf_pkg::CORDIC_ITERATIONS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [bpf_pkg::CORDIC_W-1:0]    in_angle,
    input  wire logic                                   in_neg,
    input  wire bpf_pkg::bpf_side_t                     in_side,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [bpf_pkg::CORDIC_W-1:0]         out_cos,
    output logic signed [bpf_pkg::CORDIC_W-1:0]         out_sin,
    output bpf_pkg::bpf_side_t                          out_side
);
    import bpf_pkg::*;

    logic [ITERATIONS-1:0]       valid_reg;
    logic [ITERATIONS-1:0]       adv;
    logic signed [CORDIC_W-1:0]  x_reg [ITERATIONS];
    logic signed [CORDIC_W-1:0]  y_reg [ITERATIONS];
    logic signed [CORDIC_W-1:0]  z_reg [ITERATIONS];
    logic                        neg_reg [ITERATIONS];
    bpf_side_t                   side_reg [ITERATIONS];

    genvar i;
    generate
        for (i = 0; i < ITERATIONS; i++) begin : g_stage
            logic signed [CORDIC_W-1:0] x_in, y_in, z_in;
            logic signed [CORDIC_W-1:0] x_next, y_next, z_next;
            logic                       v_in, neg_in;
            bpf_side_t                  side_in;
            logic signed [CORDIC_W-1:0] atan_val;

            // Stage input comes from the port for the first iteration.
            if (i == 0) begin : g_first
                assign x_in    = CORDIC_GAIN_Q30;
                assign y_in    = '0;
                assign z_in    = in_angle;
                assign v_in    = in_valid;
                assign neg_in  = in_neg;
                assign side_in = in_side;
            end else begin : g_next
                assign x_in    = x_reg[i-1];
                assign y_in    = y_reg[i-1];
                assign z_in    = z_reg[i-1];
                assign v_in    = valid_reg[i-1];
                assign neg_in  = neg_reg[i-1];
                assign side_in = side_reg[i-1];
            end

            // A stage loads when it is empty or its successor moves on.
            if (i == ITERATIONS - 1) begin : g_adv_last
                assign adv[i] = !valid_reg[i] || out_ready;
            end else begin : g_adv_mid
                assign adv[i] = !valid_reg[i] || adv[i+1];
            end

            assign atan_val = {{(CORDIC_W-30){1'b0}}, atan_q30(5'(i))};

            // One micro-rotation; the last stage also applies the half-turn fold.
            always_comb
            begin
                if (!z_in[CORDIC_W-1]) begin
                    x_next = x_in - (y_in >>> i);
                    y_next = y_in + (x_in >>> i);
                    z_next = z_in - atan_val;
                end else begin
                    x_next = x_in + (y_in >>> i);
                    y_next = y_in - (x_in >>> i);
                    z_next = z_in + atan_val;
                end
                if (i == ITERATIONS - 1 && neg_in) begin
                    x_next = -x_next;
                    y_next = -y_next;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[i] <= 1'b0;
                else if (adv[i])
                    valid_reg[i] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (adv[i] && v_in) begin
                    x_reg[i]    <= x_next;
                    y_reg[i]    <= y_next;
                    z_reg[i]    <= z_next;
                    neg_reg[i]  <= neg_in;
                    side_reg[i] <= side_in;
                end
            end
        end
    endgenerate

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[ITERATIONS-1];
    assign out_cos   = x_reg[ITERATIONS-1];
    assign out_sin   = y_reg[ITERATIONS-1];
    assign out_side  = side_reg[ITERATIONS-1];

endmodule

`default_nettype wire

// File: hw/rtl/branch_power_flow_unit.sv
// Top level of the branch power flow unit: input staging, CORDIC, power products.
// Depends on bpf_pkg and bpf_cordic.
`default_nettype none

// Computes active and reactive power over one branch in one direction per item.
// The block is a pipeline that takes one item in every clock cycle while the
// output side does not stall. An item passes through three input stages for
// the angle wrap and the voltage products, one stage per CORDIC iteration,
// three product stages and the output register. Each stage holds its item
// until the next one frees, so empty stages fill up while the output waits.
// No state is kept between items.
module branch_power_flow_unit #(
    parameter int CORDIC_ITERATIONS = bpf_pkg::CORDIC_ITERATIONS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // voltage_from[17:0], voltage_to[35:18], angle_from[59:36], angle_to[83:60],
    // shift_angle[107:84], conductance[139:108], susceptance[171:140],
    // shunt_susceptance[203:172], zero[207:204]
    input  wire logic [207:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // active_flow[47:0], reactive_flow[95:48]
    output logic [95:0]       m_tdata,
    // overflow[0]
    output logic [0:0]        m_tuser
);
    import bpf_pkg::*;

    // Input field unpacking.
    logic [17:0]        vk_in, vm_in;
    logic signed [23:0] af_in, at_in, sh_in;
    logic signed [31:0] g_in, b_in, bsh_in;

    assign vk_in  = s_tdata[17:0];
    assign vm_in  = s_tdata[35:18];
    assign af_in  = s_tdata[59:36];
    assign at_in  = s_tdata[83:60];
    assign sh_in  = s_tdata[107:84];
    assign g_in   = s_tdata[139:108];
    assign b_in   = s_tdata[171:140];
    assign bsh_in = s_tdata[203:172];

    // Stage handshake chain.
    logic adv1, adv2, adv3, adv4, adv5, adv6, adv_out;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic cor_in_ready, cor_out_valid;

    assign adv_out  = !m_tvalid || m_tready;
    assign adv6     = !v6_reg || adv_out;
    assign adv5     = !v5_reg || adv6;
    assign adv4     = !v4_reg || adv5;
    assign adv3     = !v3_reg || cor_in_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    // Stage 1: angle sum, voltage products, susceptance sum.
    logic signed [ANGLE_W-1:0] a1_reg;
    logic [35:0]               vkk1_reg, vkm1_reg;
    logic signed [31:0]        g1_reg, b1_reg;
    logic signed [32:0]        bbs1_reg;
    logic signed [ANGLE_W-1:0] a1_next;
    logic signed [32:0]        bbs1_next;

    assign a1_next   = ANGLE_W'(sh_in) + ANGLE_W'(af_in) - ANGLE_W'(at_in);
    assign bbs1_next = 33'(b_in) + 33'(bsh_in);

    always_ff @(posedge clk)
    begin
        if (adv1 && s_tvalid) begin
            a1_reg   <= a1_next;
            vkk1_reg <= vk_in * vk_in;
            vkm1_reg <= vk_in * vm_in;
            g1_reg   <= g_in;
            b1_reg   <= b_in;
            bbs1_reg <= bbs1_next;
        end
    end

    // Stage 2: first two wrap steps, rounding of the voltage products.
    logic signed [ANGLE_W-1:0] a2_reg, a2_next;
    logic [19:0]               vkk2_reg, vkm2_reg;
    logic signed [31:0]        g2_reg, b2_reg;
    logic signed [32:0]        bbs2_reg;
    logic [35:0]               vkk2_sum, vkm2_sum;

    assign a2_next  = wrap_step(wrap_step(a1_reg));
    assign vkk2_sum = vkk1_reg + 36'd32768;
    assign vkm2_sum = vkm1_reg + 36'd32768;

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg) begin
            a2_reg   <= a2_next;
            vkk2_reg <= vkk2_sum[35:16];
            vkm2_reg <= vkm2_sum[35:16];
            g2_reg   <= g1_reg;
            b2_reg   <= b1_reg;
            bbs2_reg <= bbs1_reg;
        end
    end

    // Stage 3: last wrap steps, quadrant fold, self-admittance products.
    logic signed [ANGLE_W-1:0]  a3_wrap, a3_fold;
    logic                       neg3_next, neg3_reg;
    logic signed [CORDIC_W-1:0] z3_reg;
    logic signed [53:0]         pa_prod;
    logic signed [54:0]         qb_prod;
    logic signed [53:0]         pa_sum;
    logic signed [54:0]         qb_sum;
    bpf_side_t                  side3_reg, side3_next;

    always_comb
    begin
        a3_wrap = wrap_step(wrap_step(a2_reg));
        if (a3_wrap > HALF_PI_Q20) begin
            a3_fold   = a3_wrap - PI_Q20;
            neg3_next = 1'b1;
        end else if (a3_wrap < -HALF_PI_Q20) begin
            a3_fold   = a3_wrap + PI_Q20;
            neg3_next = 1'b1;
        end else begin
            a3_fold   = a3_wrap;
            neg3_next = 1'b0;
        end
    end

    assign pa_prod = $signed({1'b0, vkk2_reg}) * g2_reg;
    assign qb_prod = $signed({1'b0, vkk2_reg}) * bbs2_reg;
    assign pa_sum  = pa_prod + 54'sd32768;
    assign qb_sum  = qb_prod + 55'sd32768;

    always_comb
    begin
        side3_next.vkm = vkm2_reg;
        side3_next.pa  = pa_sum[53:16];
        side3_next.qb  = qb_sum[54:16];
        side3_next.g   = g2_reg;
        side3_next.b   = b2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && v2_reg) begin
            z3_reg    <= {a3_fold[23:0], 10'd0};
            neg3_reg  <= neg3_next;
            side3_reg <= side3_next;
        end
    end

    // CORDIC rotation pipeline.
    logic signed [CORDIC_W-1:0] cos_c, sin_c;
    bpf_side_t                  side_c;

    bpf_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .in_ready  (cor_in_ready),
        .in_angle  (z3_reg),
        .in_neg    (neg3_reg),
        .in_side   (side3_reg),
        .out_valid (cor_out_valid),
        .out_ready (adv4),
        .out_cos   (cos_c),
        .out_sin   (sin_c),
        .out_side  (side_c)
    );

    // Stage 4: admittance times cosine and sine.
    logic signed [65:0] gc4_reg, bs4_reg, bc4_reg, gs4_reg;
    logic [19:0]        vkm4_reg;
    logic signed [37:0] pa4_reg;
    logic signed [38:0] qb4_reg;

    always_ff @(posedge clk)
    begin
        if (adv4 && cor_out_valid) begin
            gc4_reg  <= side_c.g * cos_c;
            bs4_reg  <= side_c.b * sin_c;
            bc4_reg  <= side_c.b * cos_c;
            gs4_reg  <= side_c.g * sin_c;
            vkm4_reg <= side_c.vkm;
            pa4_reg  <= side_c.pa;
            qb4_reg  <= side_c.qb;
        end
    end

    // Stage 5: rounded rotated admittances u and w.
    logic signed [67:0] u5_sum, w5_sum;
    logic signed [37:0] u5_reg, w5_reg;
    logic [19:0]        vkm5_reg;
    logic signed [37:0] pa5_reg;
    logic signed [38:0] qb5_reg;

    assign u5_sum = 68'(gc4_reg) + 68'(bs4_reg) + 68'sd536870912;
    assign w5_sum = 68'(bc4_reg) - 68'(gs4_reg) + 68'sd536870912;

    always_ff @(posedge clk)
    begin
        if (adv5 && v4_reg) begin
            u5_reg   <= u5_sum[67:30];
            w5_reg   <= w5_sum[67:30];
            vkm5_reg <= vkm4_reg;
            pa5_reg  <= pa4_reg;
            qb5_reg  <= qb4_reg;
        end
    end

    // Stage 6: transfer-voltage products.
    logic signed [59:0] pb_prod, qa_prod, pb_sum, qa_sum;
    logic signed [43:0] pb6_reg, qa6_reg;
    logic signed [37:0] pa6_reg;
    logic signed [38:0] qb6_reg;

    assign pb_prod = $signed({1'b0, vkm5_reg}) * u5_reg;
    assign qa_prod = $signed({1'b0, vkm5_reg}) * w5_reg;
    assign pb_sum  = pb_prod + 60'sd32768;
    assign qa_sum  = qa_prod + 60'sd32768;

    always_ff @(posedge clk)
    begin
        if (adv6 && v5_reg) begin
            pb6_reg <= pb_sum[59:16];
            qa6_reg <= qa_sum[59:16];
            pa6_reg <= pa5_reg;
            qb6_reg <= qb5_reg;
        end
    end

    // Output stage: final differences and saturation.
    logic signed [SAT_W-1:0] p_full, q_full;
    logic signed [47:0]      p_sat, q_sat;
    logic                    ovf_next;
    logic [95:0]             data_reg;
    logic                    ovf_reg;

    assign p_full = SAT_W'(pa6_reg) - SAT_W'(pb6_reg);
    assign q_full = SAT_W'(qa6_reg) - SAT_W'(qb6_reg);

    always_comb
    begin
        ovf_next = 1'b0;
        if (p_full > OUT_MAX) begin
            p_sat    = OUT_MAX[47:0];
            ovf_next = 1'b1;
        end else if (p_full < OUT_MIN) begin
            p_sat    = OUT_MIN[47:0];
            ovf_next = 1'b1;
        end else begin
            p_sat = p_full[47:0];
        end
        if (q_full > OUT_MAX) begin
            q_sat    = OUT_MAX[47:0];
            ovf_next = 1'b1;
        end else if (q_full < OUT_MIN) begin
            q_sat    = OUT_MIN[47:0];
            ovf_next = 1'b1;
        end else begin
            q_sat = q_full[47:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && v6_reg) begin
            data_reg <= {q_sat, p_sat};
            ovf_reg  <= ovf_next;
        end
    end

    // Valid bits of the top-level stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            m_tvalid <= 1'b0;
        end else begin
            if (adv1)
                v1_reg <= s_tvalid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= cor_out_valid;
            if (adv5)
                v5_reg <= v4_reg;
            if (adv6)
                v6_reg <= v5_reg;
            if (adv_out)
                m_tvalid <= v6_reg;
        end
    end

    assign m_tdata    = data_reg;
    assign m_tuser[0] = ovf_reg;

    // An empty output register means every stage is free to move.
    assert property (@(posedge clk) disable iff (!rst_n) !m_tvalid |-> s_tready)
        else $error("input stalled while the output register is empty");

    // A result taken at the output frees the whole chain.
    assert property (@(posedge clk) disable iff (!rst_n) m_tready |-> s_tready)
        else $error("input stalled while the output side is ready");

    // A flagged result carries a clamped value in at least one field.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata[47:0] == OUT_MAX[47:0] || m_tdata[47:0] == OUT_MIN[47:0] ||
             m_tdata[95:48] == OUT_MAX[47:0] || m_tdata[95:48] == OUT_MIN[47:0]))
        else $error("overflow flag without a saturated result");

endmodule

`default_nettype wire
